@@ rtl/olst_pkg.sv @@
// olst_pkg: shared types and codes for the ordered list store
// word structs for both channels, command and status codes, cell control
// no dependencies
package olst_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_READ_FWD = 2'd2,
        CMD_READ_REV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                       command;
        logic signed [VALUE_W-1:0]  value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  item;
        t_status                    status;
        logic                       last;
    } t_out_word;

    // contents of one cell
    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
    } t_slot;

    // what every cell does in a cycle
    typedef enum logic [2:0] {
        C_HOLD,
        C_ROT_L,
        C_ROT_R,
        C_INSERT,
        C_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     pos_hit;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_FINISH
    } t_state;

endpackage

@@ rtl/olst_cell.sv @@
// olst_cell: one storage cell of the list ring
// takes its neighbors' contents on rotate and remove, loads at the tail on insert
// depends on olst_pkg
module olst_cell import olst_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_head,
    input  logic                      i_tail,
    input  logic signed [VALUE_W-1:0] i_value,
    input  t_slot                     i_upper,
    input  t_slot                     i_lower,
    output t_slot                     o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    // next contents from the ring operation
    always_comb begin
        n_slot = r_slot;
        case (i_ctrl.op)
            C_HOLD: n_slot = r_slot;
            C_ROT_L: n_slot = i_upper;
            C_ROT_R: n_slot = i_lower;
            C_INSERT: begin
                // first free cell after the occupied run
                if (!r_slot.valid && (i_head || i_lower.valid)) begin
                    n_slot.valid = 1'b1;
                    n_slot.value = i_value;
                end
            end
            C_REMOVE: begin
                // close the gap from the removed position up
                if (i_ctrl.pos_hit) begin
                    if (i_tail) begin
                        n_slot.valid = 1'b0;
                    end else begin
                        n_slot = i_upper;
                    end
                end
            end
            default: n_slot = r_slot;
        endcase
    end

    // occupancy flag with reset, value without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.value <= n_slot.value;
    end

    assign o_slot = r_slot;

endmodule

@@ rtl/ordered_list_store.sv @@
// ordered_list_store: bounded ordered list of signed values on a ring of cells
// depends on olst_pkg and olst_cell
//
// The list lives in a ring of DEPTH cells, head in cell 0. An insert answers
// at once (status full when DEPTH entries are held). A delete on a non-empty
// list rotates the whole ring once past a comparator on cell 0, then removes
// the matching entry with one parallel shift and answers. A read rotates the
// ring once in the read direction and emits one word per held entry; output
// stalls hold the rotation. Deletes and reads on an empty list answer at once.
// One command is handled at a time; the next is accepted once the ring is idle
// and the output register is empty or its word is being taken.
module ordered_list_store import olst_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DEPTH - 1);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_emit;
    logic [STEP_W-1:0]         r_step;
    logic [STEP_W-1:0]         r_pos;
    logic signed [VALUE_W-1:0] r_val;
    logic                      r_dir_rev;
    logic                      r_head;
    logic                      r_found;

    logic      r_out_valid;
    t_out_word r_out_word;

    t_slot      slots [DEPTH];
    t_cell_op   cell_op;
    logic [STEP_W-1:0] eff_pos;

    logic      out_free;
    logic      in_fire;
    logic      out_load;
    t_out_word out_next;
    logic      count_inc;
    logic      count_dec;
    logic      step_adv;
    logic      emit_inc;
    logic      is_last_step;
    logic      list_empty;
    logic      list_full;
    logic      head_match;
    t_slot     observed;

    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && out_free;
    assign in_fire      = i_in_valid && o_in_ready;
    assign is_last_step = (r_step == LAST_STEP);
    assign list_empty   = (r_count == '0);
    assign list_full    = (r_count == FULL_CNT);
    assign head_match   = slots[0].valid && (slots[0].value == r_val);
    assign observed     = r_dir_rev ? slots[DEPTH-1] : slots[0];
    assign eff_pos      = r_head ? '0 : r_pos;

    // ring of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [STEP_W-1:0] CIDX = STEP_W'(g);
        t_cell_ctrl ctrl;

        assign ctrl.op      = cell_op;
        assign ctrl.pos_hit = (CIDX >= eff_pos);

        olst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_head  (g == 0),
            .i_tail  (g == DEPTH - 1),
            .i_value (i_in_word.value),
            .i_upper (slots[(g + 1) % DEPTH]),
            .i_lower (slots[(g + DEPTH - 1) % DEPTH]),
            .o_slot  (slots[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && !list_empty) begin
                    case (i_in_word.command)
                        CMD_DELETE:   n_state = S_SCAN;
                        CMD_READ_FWD: n_state = S_READ;
                        CMD_READ_REV: n_state = S_READ;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (is_last_step) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                if (out_free && is_last_step) begin
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell control and result words
    always_comb begin
        cell_op   = C_HOLD;
        out_load  = 1'b0;
        out_next  = '0;
        count_inc = 1'b0;
        count_dec = 1'b0;
        step_adv  = 1'b0;
        emit_inc  = 1'b0;
        out_next.last   = 1'b1;
        out_next.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_word.command)
                        CMD_INSERT: begin
                            out_load = 1'b1;
                            if (list_full) begin
                                out_next.status = ST_FULL;
                            end else begin
                                cell_op   = C_INSERT;
                                count_inc = 1'b1;
                            end
                        end
                        default: begin
                            // delete or read on an empty list
                            if (list_empty) begin
                                out_load        = 1'b1;
                                out_next.status = ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cell_op  = C_ROT_L;
                step_adv = 1'b1;
            end
            S_READ: begin
                if (out_free) begin
                    cell_op  = r_dir_rev ? C_ROT_R : C_ROT_L;
                    step_adv = 1'b1;
                    if (observed.valid) begin
                        out_load      = 1'b1;
                        emit_inc      = 1'b1;
                        out_next.item = observed.value;
                        out_next.last = ((r_emit + 1'b1) == r_count);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_head || r_found) begin
                        cell_op   = C_REMOVE;
                        count_dec = 1'b1;
                    end else begin
                        out_next.status = ST_NOTFOUND;
                    end
                end
            end
            default: cell_op = C_HOLD;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_emit  <= '0;
            r_step  <= '0;
            r_head  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (count_inc) begin
                r_count <= r_count + 1'b1;
            end else if (count_dec) begin
                r_count <= r_count - 1'b1;
            end
            if (in_fire) begin
                r_emit  <= '0;
                r_step  <= '0;
                r_head  <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (emit_inc) begin
                    r_emit <= r_emit + 1'b1;
                end
                if (step_adv) begin
                    r_step <= is_last_step ? '0 : r_step + 1'b1;
                end
                // match on the entry passing cell 0
                if (r_state == S_SCAN && head_match) begin
                    if (r_step == '0) begin
                        r_head <= 1'b1;
                    end else begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    // command operands and found position
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_val     <= i_in_word.value;
            r_dir_rev <= (i_in_word.command == CMD_READ_REV);
        end
        if (r_state == S_SCAN && head_match && r_step != '0) begin
            r_pos <= r_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for the ordered list store
// drives command words, predicts the result words from a shadow list, checks them
// depends on olst_pkg and ordered_list_store
module tb_top;
    import olst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_WAIT  = 3 * LIST_DEPTH;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // stimulus and prediction state
    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
    int        shadow_len     = 0;
    logic signed [VALUE_W-1:0] value_pool [8];
    logic      in_taken       = 1'b0;
    int        in_idle_pct    = 16;
    int        out_idle_pct   = 16;
    bit        hold_req       = 1'b0;
    int        hold_left      = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    ordered_list_store #(.DEPTH(LIST_DEPTH)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow list: expected result words for one accepted command word
    task automatic predict_words(input t_in_word w);
        t_out_word res;
        int        hit_pos;
        res      = '0;
        res.last = 1'b1;
        hit_pos  = -1;
        case (w.command)
            CMD_INSERT: begin
                if (shadow_len == LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = w.value;
                    shadow_len++;
                    res.status = ST_OK;
                end
                expected_words.push_back(res);
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // head match wins, otherwise the tail-most match goes
                    if (shadow_list[0] == w.value) begin
                        hit_pos = 0;
                    end else begin
                        for (int i = 1; i < shadow_len; i++)
                            if (shadow_list[i] == w.value) hit_pos = i;
                    end
                    if (hit_pos < 0) begin
                        res.status = ST_NOTFOUND;
                    end else begin
                        for (int i = hit_pos; i < shadow_len - 1; i++)
                            shadow_list[i] = shadow_list[i + 1];
                        shadow_len--;
                        res.status = ST_OK;
                    end
                end
                expected_words.push_back(res);
            end
            default: begin
                if (shadow_len == 0) begin
                    res.status = ST_EMPTY;
                    expected_words.push_back(res);
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        res.status = ST_OK;
                        res.item   = (w.command == CMD_READ_FWD) ?
                                     shadow_list[i] : shadow_list[shadow_len - 1 - i];
                        res.last   = (i == shadow_len - 1);
                        expected_words.push_back(res);
                    end
                end
            end
        endcase
    endtask

    // input side: note accepted words and predict their results
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            predict_words(in_word);
        in_taken <= rst_n && in_valid && in_ready;
    end

    // driver: next word from the pending queue, with random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk) begin
        t_out_word exp_word;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: item %0d status %0d last %0d",
                         $time, out_word.item, out_word.status, out_word.last);
                mismatch_count++;
            end else begin
                exp_word = expected_words.pop_front();
                if (out_word.item !== exp_word.item) begin
                    $display("%0t item mismatch: expected %0d got %0d",
                             $time, exp_word.item, out_word.item);
                    mismatch_count++;
                end
                if (out_word.status !== exp_word.status) begin
                    $display("%0t status mismatch: expected %0d got %0d",
                             $time, exp_word.status, out_word.status);
                    mismatch_count++;
                end
                if (out_word.last !== exp_word.last) begin
                    $display("%0t last mismatch: expected %0d got %0d",
                             $time, exp_word.last, out_word.last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_word(input t_cmd cmd, input logic signed [VALUE_W-1:0] val);
        t_in_word w;
        w.command = cmd;
        w.value   = val;
        pending_words.push_back(w);
    endtask

    // mostly pool values so deletes hit and duplicates show up
    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 80)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic queue_random(input int count, input int insert_pct, input int delete_pct);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                queue_word(CMD_INSERT, pick_value());
            else if (roll < insert_pct + delete_pct)
                queue_word(CMD_DELETE, pick_value());
            else
                queue_word($urandom_range(1) ? CMD_READ_FWD : CMD_READ_REV, $urandom);
        end
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
    endtask

    initial begin
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
        value_pool[3] = -1;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty list, extremes, head and tail-most delete, sole entry
        queue_word(CMD_READ_FWD, VAL_MAX);
        queue_word(CMD_READ_REV, VAL_MIN);
        queue_word(CMD_DELETE, '0);
        queue_word(CMD_INSERT, VAL_MAX);
        queue_word(CMD_INSERT, VAL_MIN);
        queue_word(CMD_INSERT, '0);
        queue_word(CMD_INSERT, -1);
        queue_word(CMD_INSERT, VAL_MIN);
        queue_word(CMD_READ_FWD, '0);
        queue_word(CMD_READ_REV, -1);
        queue_word(CMD_DELETE, 5);
        queue_word(CMD_DELETE, VAL_MIN);
        queue_word(CMD_DELETE, VAL_MAX);
        queue_word(CMD_READ_FWD, '0);
        queue_word(CMD_DELETE, '0);
        queue_word(CMD_DELETE, VAL_MIN);
        queue_word(CMD_DELETE, -1);
        queue_word(CMD_READ_REV, '0);
        wait_drained();

        // fill to capacity while the receiver holds off, then overflow
        hold_req = 1'b1;
        for (int i = 0; i < LIST_DEPTH + 1; i++)
            queue_word(CMD_INSERT, pick_value());
        queue_word(CMD_READ_FWD, $urandom);
        queue_word(CMD_INSERT, $urandom);
        queue_word(CMD_DELETE, value_pool[0]);
        queue_word(CMD_READ_REV, $urandom);
        wait_drained();

        // random: drain-heavy, then calm insert-heavy, then mixed
        queue_random(35, 30, 50);
        wait_drained();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        queue_random(30, 60, 25);
        wait_drained();
        in_idle_pct  = 16;
        out_idle_pct = 16;
        queue_random(25, 45, 40);
        wait_drained();

        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
